FILE: rtl/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg: shared types, constants and functions of the packet deframer
// Holds the parser phase encoding, the frame byte codes, the result word
// layout and the bytewise CRC-16/MAXIM update.
// ----------------------------------------------------------------------------
`default_nettype none

package cpd_pkg;

    localparam logic [7:0]  HDR_BYTE   = 8'hE6;
    localparam logic [7:0]  TAIL_BYTE  = 8'h6E;
    localparam logic [15:0] POLY_REFL  = 16'hA001;  // 0x8005 bit-reversed
    localparam logic [15:0] CRC_INIT   = 16'h0000;
    localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

    localparam int unsigned OUT_TDATA_W = 56;

    localparam logic        KIND_PAYLOAD   = 1'b0;
    localparam logic        KIND_FRAME_END = 1'b1;

    localparam logic [1:0]  STATUS_OK      = 2'd0;
    localparam logic [1:0]  STATUS_TAIL    = 2'd1;
    localparam logic [1:0]  STATUS_CRC     = 2'd2;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SEQ_HI  = 4'd1,
        PH_SEQ_LO  = 4'd2,
        PH_CMD     = 4'd3,
        PH_LEN_HI  = 4'd4,
        PH_LEN_LO  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CRC_HI  = 4'd7,
        PH_CRC_LO  = 4'd8,
        PH_TAIL1   = 4'd9,
        PH_TAIL2   = 4'd10
    } phase_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  payload_byte;
        logic [1:0]  frame_status;
        logic        crc_match;
        logic [15:0] sequence_id;
        logic [7:0]  command_code;
        logic [15:0] payload_length;
    } result_t;

    // One byte of reflected CRC-16, eight bit steps unrolled.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ POLY_REFL;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cpd_parser.sv
// ----------------------------------------------------------------------------
// cpd_parser: frame parser state machine
// Walks the header, fields, payload, checksum and tail one byte per cycle while
// byte_valid is high and forms at most one result for each byte it is handed.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_parser
    import cpd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       byte_valid,
    input  wire logic [7:0] rx_byte,
    input  wire logic       crc_enforce,
    output logic            res_valid,
    output result_t         res
);

    phase_t      phase_reg,        phase_next;
    logic        saw_hdr_reg,      saw_hdr_next;
    logic [15:0] seq_reg,          seq_next;
    logic [7:0]  cmd_reg,          cmd_next;
    logic [15:0] len_reg,          len_next;
    logic [15:0] count_reg,        count_next;
    logic [15:0] crc_reg,          crc_next;
    logic [15:0] rx_crc_reg,       rx_crc_next;
    logic        tail1_ok_reg,     tail1_ok_next;

    logic [15:0] crc_upd;
    logic [15:0] count_inc;
    logic        tail_ok;
    logic        match;

    assign crc_upd   = crc16_byte(crc_reg, rx_byte);
    assign count_inc = count_reg + 16'd1;
    assign tail_ok   = tail1_ok_reg && (rx_byte == TAIL_BYTE);
    assign match     = (rx_crc_reg == (crc_reg ^ CRC_XOROUT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            saw_hdr_reg  <= 1'b0;
            seq_reg      <= '0;
            cmd_reg      <= '0;
            len_reg      <= '0;
            count_reg    <= '0;
            crc_reg      <= CRC_INIT;
            rx_crc_reg   <= '0;
            tail1_ok_reg <= 1'b0;
        end else if (byte_valid) begin
            phase_reg    <= phase_next;
            saw_hdr_reg  <= saw_hdr_next;
            seq_reg      <= seq_next;
            cmd_reg      <= cmd_next;
            len_reg      <= len_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            rx_crc_reg   <= rx_crc_next;
            tail1_ok_reg <= tail1_ok_next;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        saw_hdr_next  = saw_hdr_reg;
        seq_next      = seq_reg;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        rx_crc_next   = rx_crc_reg;
        tail1_ok_next = tail1_ok_reg;

        res_valid          = 1'b0;
        res.out_kind       = KIND_PAYLOAD;
        res.payload_byte   = 8'h00;
        res.frame_status   = STATUS_OK;
        res.crc_match      = 1'b0;
        res.sequence_id    = seq_reg;
        res.command_code   = cmd_reg;
        res.payload_length = len_reg;

        unique case (phase_reg)
            PH_SEQ_HI: begin
                seq_next   = {rx_byte, 8'h00};
                crc_next   = crc_upd;
                phase_next = PH_SEQ_LO;
            end
            PH_SEQ_LO: begin
                seq_next   = {seq_reg[15:8], rx_byte};
                crc_next   = crc_upd;
                phase_next = PH_CMD;
            end
            PH_CMD: begin
                cmd_next   = rx_byte;
                crc_next   = crc_upd;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_next   = {rx_byte, 8'h00};
                crc_next   = crc_upd;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_next   = {len_reg[15:8], rx_byte};
                crc_next   = crc_upd;
                count_next = '0;
                // An empty payload goes straight on to the checksum.
                phase_next = ({len_reg[15:8], rx_byte} == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                crc_next   = crc_upd;
                count_next = count_inc;
                if (count_inc == len_reg) begin
                    phase_next = PH_CRC_HI;
                end
                res_valid        = 1'b1;
                res.payload_byte = rx_byte;
            end
            PH_CRC_HI: begin
                rx_crc_next = {rx_byte, 8'h00};
                phase_next  = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                rx_crc_next = {rx_crc_reg[15:8], rx_byte};
                phase_next  = PH_TAIL1;
            end
            PH_TAIL1: begin
                tail1_ok_next = (rx_byte == TAIL_BYTE);
                phase_next    = PH_TAIL2;
            end
            PH_TAIL2: begin
                res_valid     = 1'b1;
                res.out_kind  = KIND_FRAME_END;
                res.crc_match = match;
                // A bad tail outranks a checksum mismatch.
                if (!tail_ok) begin
                    res.frame_status = STATUS_TAIL;
                end else if (crc_enforce && !match) begin
                    res.frame_status = STATUS_CRC;
                end
                phase_next   = PH_HUNT;
                saw_hdr_next = 1'b0;
            end
            default: begin
                if ((rx_byte == HDR_BYTE) && saw_hdr_reg) begin
                    saw_hdr_next = 1'b0;
                    crc_next     = CRC_INIT;
                    count_next   = '0;
                    phase_next   = PH_SEQ_HI;
                end else begin
                    saw_hdr_next = (rx_byte == HDR_BYTE);
                    phase_next   = PH_HUNT;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/cpd_out_buf.sv
// ----------------------------------------------------------------------------
// cpd_out_buf: result register with skid stage
// Holds finished results for the output channel so that the input side
// can still hand over one more result after the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_out_buf
    import cpd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  var  result_t push_data,
    output logic         push_ready,
    output logic         out_valid,
    output result_t      out_data,
    input  wire logic    out_ready
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg,       main_next;
    result_t skid_reg,       skid_next;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end else if (push) begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/crc16_framed_packet_deframer.sv
// ----------------------------------------------------------------------------
// crc16_framed_packet_deframer: CRC-16/MAXIM framed packet deframer
// Parses E6 E6 framed packets from a received byte stream, passes payload
// bytes out and reports one frame-end word per frame with its status.
// ----------------------------------------------------------------------------
//
//  Channel   Ports        Width  Contents
//  --------  -----------  -----  -------------------------------------------
//  input     s_axis_*     8      one received byte per word
//  output    m_axis_*     56+1   payload byte or frame-end report, kind in tuser
//  config    cfg_wr_*     1      crc_enforce, written while idle
//
//  Each accepted byte is handled in the cycle it is taken: the parser state
//  machine and the unrolled CRC byte update sit between the parser registers
//  and the result register, so one byte is taken every cycle while
//  s_axis_tready is high; results wait in the skid stage while the output stalls.
//  s_axis_tready drops only when both the result register and the skid stage
//  hold words, i.e. once a result has had to wait in the skid stage.
//  aresetn is synchronous and active low; it returns the parser to header
//  hunting, empties the output stage and clears crc_enforce.
//
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_framed_packet_deframer
    import cpd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [7:0] rx_byte
    input  wire logic [7:0]             s_axis_tdata,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [7:0] payload_byte, [9:8] frame_status, [10] crc_match,
    // [26:11] sequence_id, [34:27] command_code, [50:35] payload_length,
    // [55:51] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // [0] out_kind: 0 payload byte, 1 frame end
    output logic                        m_axis_tuser,

    input  wire logic                   cfg_wr_en,
    input  wire logic                   cfg_wr_data
);

    logic    crc_enforce_reg;
    logic    byte_accept;
    logic    res_valid;
    result_t res;
    result_t out_word;

    // The user must change the enforcement bit only while no frame is in flight; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_enforce_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            crc_enforce_reg <= cfg_wr_data;
        end
    end

    assign byte_accept = s_axis_tvalid && s_axis_tready;

    cpd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_valid  (byte_accept),
        .rx_byte     (s_axis_tdata),
        .crc_enforce (crc_enforce_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // A result is only produced for an accepted byte.
    cpd_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (byte_accept && res_valid),
        .push_data  (res),
        .push_ready (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_data   (out_word),
        .out_ready  (m_axis_tready)
    );

    assign m_axis_tuser = out_word.out_kind;
    assign m_axis_tdata = {5'b00000,
                           out_word.payload_length,
                           out_word.command_code,
                           out_word.sequence_id,
                           out_word.crc_match,
                           out_word.frame_status,
                           out_word.payload_byte};

endmodule

`default_nettype wire

FILE: rtl/cpd_checker.sv
// ----------------------------------------------------------------------------
// cpd_checker: port-level checks of the packet deframer
// Watches the output channel for words that break the result layout or the
// reset behavior; attached to the top level by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_checker
    import cpd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                   m_axis_tuser
);

    // Reset leaves the output stage empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output word present after reset");

    // A stalled word keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

    // Payload words carry no status or checksum flag.
    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == KIND_PAYLOAD) |-> m_axis_tdata[10:8] == 3'b000)
        else $error("payload word with status bits set");

    // Frame-end words have no payload byte and a legal status.
    a_end_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == KIND_FRAME_END) |->
            (m_axis_tdata[7:0] == 8'h00) && (m_axis_tdata[9:8] != 2'd3))
        else $error("malformed frame-end word");

    // A CRC error is only reported when the checksum did not match.
    a_crc_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[9:8] == STATUS_CRC) |-> !m_axis_tdata[10])
        else $error("CRC error reported with matching checksum");

endmodule

bind crc16_framed_packet_deframer cpd_checker u_cpd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for crc16_framed_packet_deframer
// Streams framed packets and noise into the deframer under varied idle and
// stall patterns, tracks the expected payload and frame-end words with an
// independent parser model, and compares every output word field by field.
// ----------------------------------------------------------------------------

module tb_top;

    import cpd_pkg::*;

    // Longest stretch without any word moving before the run is declared hung.
    // The long receiver hold-off below is well inside it.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    // Quiet cycles granted after the last expected word before a register
    // write, so that trailing bytes that make no word have been digested.
    localparam int DRAIN_CYCLES   = 4;

    // One output word as the parser model predicts it.
    typedef struct {
        logic        kind;
        logic [7:0]  pbyte;
        logic [1:0]  status;
        logic        match;
        logic [15:0] seq;
        logic [7:0]  cmd;
        logic [15:0] len;
    } deframe_word_t;

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = 8'h00;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_wr_en     = 1'b0;
    logic                   cfg_wr_data   = 1'b0;

    // Parser model state, advanced once per accepted input byte.
    phase_t      rx_phase   = PH_HUNT;
    logic        hdr_seen   = 1'b0;
    logic [15:0] fr_seq     = 16'h0000;
    logic [7:0]  fr_cmd     = 8'h00;
    logic [15:0] fr_len     = 16'h0000;
    logic [15:0] pay_count  = 16'h0000;
    logic [15:0] crc_acc    = CRC_INIT;
    logic [15:0] crc_rcvd   = 16'h0000;
    logic        tail1_good = 1'b0;
    logic        enforce_crc = 1'b0;

    deframe_word_t expected_words[$];
    logic [7:0]    frame_payload[$];

    int unsigned err_count     = 0;
    int unsigned bytes_sent    = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;

    // The test sequence flips hold_toggle to ask the receiver for a long
    // hold-off; the receiver process owns the countdown.
    bit          hold_toggle = 1'b0;
    bit          hold_seen   = 1'b0;
    int unsigned hold_left   = 0;

    crc16_framed_packet_deframer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------

    // Reflected CRC-16 update, one data bit folded into the feedback per step.
    function automatic logic [15:0] crc_maxim_step(input logic [15:0] crc,
                                                   input logic [7:0]  data);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb  = crc[0] ^ data[i];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ POLY_REFL;
            end
        end
        return crc;
    endfunction

    // Advances the parser model by one byte and queues the word it produces,
    // if any. Only payload bytes and the second tail byte produce a word.
    task automatic parse_rx_byte(input logic [7:0] b);
        deframe_word_t w;
        logic          emit;
        logic          tail_ok;
        w    = '{default: '0};
        emit = 1'b0;
        case (rx_phase)
            PH_SEQ_HI: begin
                fr_seq   = {b, 8'h00};
                crc_acc  = crc_maxim_step(crc_acc, b);
                rx_phase = PH_SEQ_LO;
            end
            PH_SEQ_LO: begin
                fr_seq[7:0] = b;
                crc_acc     = crc_maxim_step(crc_acc, b);
                rx_phase    = PH_CMD;
            end
            PH_CMD: begin
                fr_cmd   = b;
                crc_acc  = crc_maxim_step(crc_acc, b);
                rx_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                fr_len   = {b, 8'h00};
                crc_acc  = crc_maxim_step(crc_acc, b);
                rx_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                fr_len[7:0] = b;
                crc_acc     = crc_maxim_step(crc_acc, b);
                pay_count   = 16'h0000;
                // An empty payload skips straight to the checksum.
                rx_phase    = (fr_len == 16'h0000) ? PH_CRC_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                crc_acc   = crc_maxim_step(crc_acc, b);
                pay_count = pay_count + 16'd1;
                if (pay_count == fr_len) begin
                    rx_phase = PH_CRC_HI;
                end
                w.kind  = KIND_PAYLOAD;
                w.pbyte = b;
                emit    = 1'b1;
            end
            PH_CRC_HI: begin
                crc_rcvd = {b, 8'h00};
                rx_phase = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                crc_rcvd[7:0] = b;
                rx_phase      = PH_TAIL1;
            end
            PH_TAIL1: begin
                tail1_good = (b == TAIL_BYTE);
                rx_phase   = PH_TAIL2;
            end
            PH_TAIL2: begin
                tail_ok = tail1_good && (b == TAIL_BYTE);
                w.kind  = KIND_FRAME_END;
                w.match = (crc_rcvd == (crc_acc ^ CRC_XOROUT));
                // A bad tail wins over a bad checksum; a bad checksum only
                // counts as an error while enforcement is on.
                if (!tail_ok) begin
                    w.status = STATUS_TAIL;
                end else if (enforce_crc && !w.match) begin
                    w.status = STATUS_CRC;
                end else begin
                    w.status = STATUS_OK;
                end
                emit     = 1'b1;
                rx_phase = PH_HUNT;
                hdr_seen = 1'b0;
            end
            default: begin
                // Header hunt: two header bytes in a row start a frame.
                if (b == HDR_BYTE && hdr_seen) begin
                    hdr_seen  = 1'b0;
                    crc_acc   = CRC_INIT;
                    pay_count = 16'h0000;
                    rx_phase  = PH_SEQ_HI;
                end else begin
                    hdr_seen = (b == HDR_BYTE);
                    rx_phase = PH_HUNT;
                end
            end
        endcase
        if (emit) begin
            w.seq = fr_seq;
            w.cmd = fr_cmd;
            w.len = fr_len;
            expected_words.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    function automatic void note_field(input string name, input logic [15:0] exp_v,
                                       input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            $display("%0t: %s mismatch: expected %h, actual %h",
                     $time, name, exp_v, act_v);
        end
    endfunction

    // Compares the output word just accepted with the oldest expectation.
    task automatic check_word();
        deframe_word_t e;
        if (expected_words.size() == 0) begin
            err_count++;
            $display("%0t: unexpected output word: expected none, actual tdata=%h tuser=%b",
                     $time, m_axis_tdata, m_axis_tuser);
            return;
        end
        e = expected_words.pop_front();
        note_field("out_kind",       16'(e.kind),   16'(m_axis_tuser));
        note_field("payload_byte",   16'(e.pbyte),  16'(m_axis_tdata[7:0]));
        note_field("frame_status",   16'(e.status), 16'(m_axis_tdata[9:8]));
        note_field("crc_match",      16'(e.match),  16'(m_axis_tdata[10]));
        note_field("sequence_id",    e.seq,         m_axis_tdata[26:11]);
        note_field("command_code",   16'(e.cmd),    16'(m_axis_tdata[34:27]));
        note_field("payload_length", e.len,         m_axis_tdata[50:35]);
        note_field("tdata_padding",  16'h0000,      16'(m_axis_tdata[55:51]));
    endtask

    // Both channels are sampled at the rising edge, before the edge's own
    // updates land. The output side is checked first; a byte accepted at
    // this edge cannot produce a word that leaves at the same edge anyway.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_word();
            end
            if (s_axis_tvalid && s_axis_tready) begin
                parse_rx_byte(s_axis_tdata);
            end
        end
    end

    // Watchdog: any accepted word or register write counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d words still expected",
                     $time, WATCHDOG_LIMIT, expected_words.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stalls at the current rate, or a long hold-off when
    // the test sequence asks for one.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Offers one byte after a random idle gap and returns once it has been
    // accepted. tvalid stays high, so back-to-back bytes leave no bubble.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        bytes_sent++;
    endtask

    // Sends a complete frame carrying frame_payload. crc_flip is XORed into
    // the correct checksum, so any nonzero value makes it wrong.
    task automatic send_frame(input logic [15:0] seq, input logic [7:0] cmd,
                              input logic [15:0] crc_flip,
                              input logic [7:0] tail_a, input logic [7:0] tail_b);
        logic [15:0] len;
        logic [15:0] crc;
        logic [7:0]  lead[5];
        len  = 16'(frame_payload.size());
        lead = '{seq[15:8], seq[7:0], cmd, len[15:8], len[7:0]};
        crc  = CRC_INIT;
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        foreach (lead[i]) begin
            crc = crc_maxim_step(crc, lead[i]);
            send_byte(lead[i]);
        end
        foreach (frame_payload[i]) begin
            crc = crc_maxim_step(crc, frame_payload[i]);
            send_byte(frame_payload[i]);
        end
        crc = crc ^ CRC_XOROUT ^ crc_flip;
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
        send_byte(tail_a);
        send_byte(tail_b);
    endtask

    // Stops offering bytes and waits until every expected word has left,
    // plus DRAIN_CYCLES quiet cycles for bytes that produce no word.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic enforce);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= enforce;
        @(posedge aclk);
        enforce_crc = enforce;
        cfg_wr_en   <= 1'b0;
    endtask

    // Right after reset enforcement is off: a bad checksum is reported with
    // crc_match low but an ok status. A good one-byte frame follows.
    task automatic test_reset_state();
        frame_payload.delete();
        send_frame(16'hFFFF, 8'hFF, 16'h0001, TAIL_BYTE, TAIL_BYTE);
        frame_payload.push_back(8'hFF);
        send_frame(16'h0000, 8'h00, 16'h0000, TAIL_BYTE, TAIL_BYTE);
    endtask

    // Lone header bytes are dropped. The frame's sequence id starts with the
    // header byte, so E6 E6 E6 appears and the first two must form the header.
    task automatic test_header_hunt();
        send_byte(8'h00);
        send_byte(HDR_BYTE);
        send_byte(8'hFF);
        frame_payload.delete();
        frame_payload.push_back(8'h00);
        frame_payload.push_back(8'hFF);
        send_frame(16'hE601, 8'h00, 16'h0000, TAIL_BYTE, TAIL_BYTE);
    endtask

    // With enforcement on: checksum error alone, a bad first tail byte
    // together with a bad checksum (tail error wins), and a bad second tail.
    task automatic test_frame_errors();
        cfg_write(1'b1);
        frame_payload.delete();
        frame_payload.push_back(8'h5A);
        send_frame(16'h1234, 8'h42, 16'h8000, TAIL_BYTE, TAIL_BYTE);
        send_frame(16'h1235, 8'h43, 16'h0101, 8'h00, TAIL_BYTE);
        send_frame(16'h1236, 8'h44, 16'h0000, TAIL_BYTE, HDR_BYTE);
    endtask

    // Mostly well-formed frames with random content, mixed with corrupted
    // checksums, bad tails and short bursts of noise between frames.
    task automatic test_random_traffic(input int unsigned src_pct,
                                       input int unsigned snk_pct,
                                       input logic enforce, input int unsigned n_bytes);
        int unsigned start;
        int unsigned plen;
        logic [7:0]  nb;
        logic [7:0]  prev;
        logic [15:0] seq;
        logic [7:0]  cmd;
        logic [15:0] flip;
        logic [7:0]  ta;
        logic [7:0]  tb;
        cfg_write(enforce);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            if ($urandom_range(99) < 12) begin
                // Noise never holds two header bytes in a row and never ends
                // on one, so the next frame's header is seen where it starts.
                prev = 8'h00;
                repeat ($urandom_range(6, 1)) begin
                    nb = ($urandom_range(3) == 0) ? HDR_BYTE : 8'($urandom);
                    if (nb == HDR_BYTE && prev == HDR_BYTE) begin
                        nb = ~HDR_BYTE;
                    end
                    send_byte(nb);
                    prev = nb;
                end
                if (prev == HDR_BYTE) begin
                    send_byte(TAIL_BYTE);
                end
            end else begin
                plen = ($urandom_range(9) == 0) ? $urandom_range(48, 13)
                                                : $urandom_range(12, 0);
                frame_payload.delete();
                repeat (plen) frame_payload.push_back(8'($urandom));
                seq = 16'($urandom);
                if ($urandom_range(7) == 0) begin
                    seq = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                end
                cmd = 8'($urandom);
                if ($urandom_range(7) == 0) begin
                    cmd = $urandom_range(1) ? 8'hFF : 8'h00;
                end
                flip = ($urandom_range(99) < 15) ? 16'($urandom_range(16'hFFFF, 1))
                                                 : 16'h0000;
                ta = TAIL_BYTE;
                tb = TAIL_BYTE;
                if ($urandom_range(99) < 10) begin
                    ta = 8'($urandom);
                    if ($urandom_range(1)) begin
                        tb = 8'($urandom);
                    end
                end
                send_frame(seq, cmd, flip, ta, tb);
            end
        end
    endtask

    // The receiver holds off for a long stretch while a frame with a 300-byte
    // payload is offered back to back, so the output stage fills and the input stalls.
    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        frame_payload.delete();
        repeat (300) frame_payload.push_back(8'($urandom));
        hold_toggle = ~hold_toggle;
        send_frame(16'h8000, 8'h80, 16'h0000, TAIL_BYTE, TAIL_BYTE);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_header_hunt();
        test_frame_errors();
        test_random_traffic(0,  0,  1'b0, 220);
        test_random_traffic(45, 0,  1'b1, 220);
        test_random_traffic(0,  45, 1'b0, 220);
        test_random_traffic(9,  9,  1'b1, 220);
        test_backpressure();
        drain_results();

        if (err_count == 0 && expected_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/cpd_pkg.sv
rtl/cpd_parser.sv
rtl/cpd_out_buf.sv
rtl/crc16_framed_packet_deframer.sv
rtl/cpd_checker.sv
sim/tb_top.sv
